FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the response line matcher.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define RLM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("response line matcher assertion failed");

// Check a property at every rising edge, reset included.
`define RLM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("response line matcher assertion failed");

`endif

FILE: rtl/rlm_pkg.sv
// Package for the response line matcher: response string ROM, codes and helpers.
// No dependencies.
`default_nettype none

package rlm_pkg;

    localparam int NUM_STRINGS  = 12;
    localparam int ROM_MAX_LEN  = 42;
    localparam int ROM_POS_W    = $clog2(ROM_MAX_LEN);
    localparam int CODE_W       = 4;

    localparam logic [CODE_W-1:0] CODE_UNKNOWN = 4'd12;
    localparam logic [7:0]        CH_CR        = 8'h0D;
    localparam logic [7:0]        CH_LF        = 8'h0A;

    typedef logic [ROM_MAX_LEN*8-1:0] rom_text_t;
    typedef logic [CODE_W-1:0]        code_t;

    // Strings right-justified: last character in the low byte, zero padding above.
    localparam rom_text_t ROM_TEXT [NUM_STRINGS] = '{
        "Successfully actuated mechanical brake\r\n",
        "Failed to actuate mechanical brake\r\n",
        "Timeout while actuating mechanical brake\r\n",
        "SMA retracted\r\n",
        "SMA extending\r\n",
        "SMA extended\r\n",
        "BLDC motor speed stabilized\r\n",
        "BLDC motor timeout\r\n",
        "BLDC motor acceleration complete\r\n",
        "BLDC motor coasting to stop\r\n",
        "BLDC motor stopped\r\n",
        "Motion primitive unrecognized\r\n"
    };

    function automatic int rom_len(input rom_text_t text);
        int n;
        n = 0;
        for (int k = 0; k < ROM_MAX_LEN; k++)
        begin
            if (text[k*8 +: 8] != 8'h00)
            begin
                n = k + 1;
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rlm_byte_if.sv
// Received byte channel: valid/ready handshake carrying one rx_byte per item.
// No dependencies.
`default_nettype none

interface rlm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/rlm_code_if.sv
// Response code channel: valid/ready handshake carrying one response_code per item.
// No dependencies.
`default_nettype none

interface rlm_code_if;
    logic       valid;
    logic       ready;
    logic [3:0] response_code;

    modport source (output valid, output response_code, input ready);
    modport sink   (input valid, input response_code, output ready);
endinterface

`default_nettype wire

FILE: rtl/response_line_matcher_top.sv
// Output: a line feed that ends a line gives its registered code in the cycle after acceptance.
// Throughput: one byte per cycle; the only stall is a held, untaken code register.
// Per-byte work is twelve parallel ROM compares on the line position counter.
// Reset: all candidates live, empty line, no code pending.
// Depends on rlm_pkg, rlm_byte_if, rlm_code_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module response_line_matcher_top
    import rlm_pkg::*;
#(
    parameter int LINE_MAX = 64
)
(
    input  wire              clk,
    input  wire              rst_n,
    rlm_byte_if.sink         rx,
    rlm_code_if.source       resp
);

    localparam int CNT_W = $clog2(LINE_MAX + 1);

    logic [NUM_STRINGS-1:0] alive_reg;
    logic [NUM_STRINGS-1:0] alive_next;
    logic [NUM_STRINGS-1:0] at_last;
    logic [CNT_W-1:0]       length_reg;
    logic                   prev_cr_reg;
    logic                   resp_valid_reg;
    code_t                  code_reg;
    code_t                  code_next;
    logic                   accept;
    logic                   line_end;

    assign rx.ready           = !resp_valid_reg || resp.ready;
    assign accept             = rx.valid && rx.ready;
    assign line_end           = (rx.rx_byte == CH_LF) && prev_cr_reg;
    assign resp.valid         = resp_valid_reg;
    assign resp.response_code = code_reg;

    for (genvar i = 0; i < NUM_STRINGS; i++)
    begin : g_lane
        localparam int LEN = rom_len(ROM_TEXT[i]);

        logic                 in_range;
        logic [ROM_POS_W-1:0] off;
        rom_text_t            shifted;

        assign in_range = length_reg < CNT_W'(LEN);
        assign off      = in_range ? ROM_POS_W'(LEN - 1) - length_reg[ROM_POS_W-1:0]
                                   : '0;
        assign shifted  = ROM_TEXT[i] >> {off, 3'b000};

        assign alive_next[i] = alive_reg[i] && in_range && (shifted[7:0] == rx.rx_byte);
        assign at_last[i]    = length_reg == CNT_W'(LEN - 1);
    end

    always_comb
    begin
        code_next = CODE_UNKNOWN;
        for (int i = NUM_STRINGS - 1; i >= 0; i--)
        begin
            if (alive_next[i] && at_last[i])
            begin
                code_next = CODE_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg      <= '1;
            length_reg     <= '0;
            prev_cr_reg    <= 1'b0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && line_end)
            begin
                resp_valid_reg <= 1'b1;
            end
            else if (resp.ready)
            begin
                resp_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                if (line_end)
                begin
                    alive_reg   <= '1;
                    length_reg  <= '0;
                    prev_cr_reg <= 1'b0;
                end
                else
                begin
                    alive_reg   <= alive_next;
                    prev_cr_reg <= rx.rx_byte == CH_CR;
                    if (length_reg < CNT_W'(LINE_MAX))
                    begin
                        length_reg <= length_reg + CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && line_end)
        begin
            code_reg <= code_next;
        end
    end

    `RLM_ASSERT(a_line_end_gives_code,
        (accept && line_end) |=> (resp_valid_reg && length_reg == '0 && alive_reg == '1))
    `RLM_ASSERT(a_length_saturates, length_reg <= CNT_W'(LINE_MAX))
    `RLM_ASSERT(a_code_in_range, resp_valid_reg |-> (code_reg <= CODE_UNKNOWN))
    `RLM_ASSERT(a_no_accept_when_blocked,
        (resp_valid_reg && !resp.ready) |-> !rx.ready)

endmodule

`default_nettype wire
